@@ hdl/pwltc_pkg.sv @@
package pwltc_pkg;

  // Field widths fixed by the interface
  localparam int LEVEL_W   = 8;
  localparam int CHAN_W    = 2;
  localparam int KIDX_W    = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int NUMER_W   = 2 * LEVEL_W;

  // Register file and curve limits
  localparam int NUM_CFG       = 3;
  localparam int MIN_KNOTS     = 2;
  localparam int MAX_KNOTS_DEF = 16;
  localparam int CHANNELS_DEF  = 3;

  // Item operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KNOTS_CH0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KNOTS_CH1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KNOTS_CH2 = 2'd2;

  // One stored knot
  typedef struct packed {
    logic [LEVEL_W-1:0] level_in;
    logic [LEVEL_W-1:0] level_out;
  } knot_t;

  // Divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ hdl/pwltc_knot_mem.sv @@
module pwltc_knot_mem #(
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  pwltc_pkg::knot_t  wdata,
  input  logic [AW-1:0]     raddr,
  output pwltc_pkg::knot_t  rdata
);
  import pwltc_pkg::*;

  knot_t mem [DEPTH];

  // Write one knot, read one knot a cycle with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/pwltc_divider.sv @@
module pwltc_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pwltc_pkg::NUMER_W-1:0]   numer,
  input  logic [pwltc_pkg::LEVEL_W-1:0]   denom,
  output logic [pwltc_pkg::LEVEL_W-1:0]   quotient,
  output pwltc_pkg::div_status_t          status
);
  import pwltc_pkg::*;

  localparam int STEP_W = $clog2(LEVEL_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LEVEL_W - 1);

  logic [LEVEL_W-1:0] rem;
  logic [LEVEL_W-1:0] rem_next;
  logic [LEVEL_W-1:0] shreg;
  logic [LEVEL_W-1:0] den;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;
  logic [LEVEL_W:0]   trial;
  logic [LEVEL_W:0]   diff;
  logic               ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, shreg[LEVEL_W-1]};
    diff     = trial - {1'b0, den};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Upper byte seeds the remainder; quotient bits shift in from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= numer[NUMER_W-1:LEVEL_W];
      shreg <= numer[LEVEL_W-1:0];
      den   <= denom;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[LEVEL_W-2:0], ge};
    end
  end

  assign quotient    = shreg;
  assign status.busy = busy;
  assign status.done = done;

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < den)
    else $error("divider remainder not below divisor");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> den > 8'd1)
    else $error("divider running on divisor below two");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && step == '0)
    else $error("divider did not start");

endmodule

@@ hdl/piecewise_linear_tone_curve.sv @@
// Channel   Direction  Handshake                 Payload
// item      in         item_valid/item_ready     op, channel, knot_index, knot levels, pixel
// result    out        result_valid/result_ready mapped, out_channel
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// A load, or a map on a channel at or above CHANNELS, yields no result.
// A map scans up to k knots, one a cycle from the knot memory's single read port, and fills the
// result register from S_DONE on a knot hit or outside the curve, or after S_PREP and S_DIV
// when it interpolates (setup, then a serial divide that forms the quotient one bit at a time).
// Reset clears the controller and result_valid and sets every knot count to two;
// the knot memory holds nothing until loaded. A full result register holds the map in S_DONE.
module piecewise_linear_tone_curve #(
  parameter int MAX_KNOTS = pwltc_pkg::MAX_KNOTS_DEF,
  parameter int CHANNELS  = pwltc_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              op,
  input  logic [pwltc_pkg::CHAN_W-1:0]      channel,
  input  logic [pwltc_pkg::KIDX_W-1:0]      knot_index,
  input  logic [pwltc_pkg::LEVEL_W-1:0]     knot_level_in,
  input  logic [pwltc_pkg::LEVEL_W-1:0]     knot_level_out,
  input  logic [pwltc_pkg::LEVEL_W-1:0]     pixel,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [pwltc_pkg::LEVEL_W-1:0]     mapped,
  output logic [pwltc_pkg::CHAN_W-1:0]      out_channel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwltc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwltc_pkg::CFG_W-1:0]       cfg_data
);
  import pwltc_pkg::*;

  localparam int DEPTH = CHANNELS * MAX_KNOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = $clog2(MAX_KNOTS);
  localparam logic [7:0] MAXK8 = 8'(MAX_KNOTS);
  localparam logic [7:0] MINK8 = 8'(MIN_KNOTS);
  localparam logic [CHAN_W:0] CHAN_LIM = (CHAN_W+1)'(CHANNELS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [CFG_W-1:0]    knots_ch0;
  logic [CFG_W-1:0]    knots_ch1;
  logic [CFG_W-1:0]    knots_ch2;
  logic [CHAN_W-1:0]   ch_r;
  logic [LEVEL_W-1:0]  pix_r;
  logic [AW-1:0]       base_r;
  logic [KW-1:0]       last_r;
  logic [KW-1:0]       j;
  knot_t               prev;
  knot_t               cur;
  logic [LEVEL_W-1:0]  res;

  logic                item_acc;
  logic                chan_ok;
  logic [AW-1:0]       in_base;
  logic [7:0]          cnt8;
  logic [7:0]          n8;
  logic [KW-1:0]       in_last;
  logic                mem_we;
  logic [AW-1:0]       waddr;
  knot_t               wdata;
  logic [AW-1:0]       raddr;
  knot_t               rdata;
  logic                div_start;
  logic [NUMER_W-1:0]  numer;
  logic [LEVEL_W-1:0]  dx;
  logic [LEVEL_W-1:0]  quotient;
  div_status_t         div_st;
  logic                res_free;

  // Configuration registers take a write every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      knots_ch0 <= CFG_W'(MIN_KNOTS);
      knots_ch1 <= CFG_W'(MIN_KNOTS);
      knots_ch2 <= CFG_W'(MIN_KNOTS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KNOTS_CH0: knots_ch0 <= cfg_data;
        REG_KNOTS_CH1: knots_ch1 <= cfg_data;
        REG_KNOTS_CH2: knots_ch2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the incoming item
  assign item_ready = (state == S_IDLE);
  assign item_acc   = item_valid && item_ready;
  assign chan_ok    = {1'b0, channel} < CHAN_LIM;
  assign in_base    = chan_ok ? AW'(32'(channel) * MAX_KNOTS) : '0;

  // Clamp the knot count of the addressed channel
  always_comb begin
    case (channel)
      REG_KNOTS_CH0: cnt8 = 8'(knots_ch0);
      REG_KNOTS_CH1: cnt8 = 8'(knots_ch1);
      REG_KNOTS_CH2: cnt8 = 8'(knots_ch2);
      default:       cnt8 = MINK8;
    endcase
    if (cnt8 < MINK8) begin
      n8 = MINK8;
    end else if (cnt8 > MAXK8) begin
      n8 = MAXK8;
    end else begin
      n8 = cnt8;
    end
    in_last = KW'(n8 - 8'd1);
  end

  // Knot loads go straight to memory
  assign mem_we = item_acc && (op == OP_LOAD) && chan_ok && (8'(knot_index) < MAXK8);
  assign waddr  = in_base + AW'(knot_index);
  assign wdata  = '{level_in: knot_level_in, level_out: knot_level_out};

  // Issue the first knot on acceptance, then the next knot while one is compared
  always_comb begin
    if (state == S_SEARCH) begin
      raddr = base_r + AW'((j < last_r) ? j + 1'b1 : j);
    end else begin
      raddr = in_base;
    end
  end

  pwltc_knot_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Blend the two surrounding knots: y0*(x1-v) + y1*(v-x0)
  assign dx        = cur.level_in - prev.level_in;
  assign numer     = NUMER_W'(prev.level_out * (cur.level_in - pix_r))
                   + NUMER_W'(cur.level_out * (pix_r - prev.level_in));
  assign div_start = (state == S_PREP);

  pwltc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (dx),
    .quotient (quotient),
    .status   (div_st)
  );

  assign res_free = !result_valid || result_ready;

  // Controller
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_acc && (op == OP_MAP) && chan_ok) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (rdata.level_in >= pix_r) begin
          if (rdata.level_in == pix_r || j == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_PREP;
          end
        end else if (j == last_r) begin
          state_next = S_DONE;
        end
      end
      S_PREP: state_next = S_DIV;
      S_DIV: begin
        if (div_st.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the map and walk the knots
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_acc) begin
          ch_r   <= channel;
          pix_r  <= pixel;
          base_r <= in_base;
          last_r <= in_last;
          j      <= '0;
        end
      end
      S_SEARCH: begin
        if (rdata.level_in >= pix_r) begin
          cur <= rdata;
          res <= rdata.level_out;
        end else begin
          prev <= rdata;
          res  <= rdata.level_out;
          if (j != last_r) begin
            j <= j + 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          res <= quotient;
        end
      end
      default: ;
    endcase
  end

  // Result register: hold until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && res_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && res_free) begin
      mapped      <= res;
      out_channel <= ch_r;
    end
  end

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> j <= last_r)
    else $error("knot search ran past the last knot");

  a_segment_brackets: assert property (@(posedge clk) disable iff (rst)
    state == S_PREP |-> prev.level_in < pix_r && cur.level_in > pix_r)
    else $error("interpolation segment does not bracket the pixel");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_map_starts: assert property (@(posedge clk) disable iff (rst)
    item_acc && op == OP_MAP && chan_ok |=> state == S_SEARCH && j == '0)
    else $error("accepted map did not start a search");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import pwltc_pkg::*;

  localparam int MAX_KNOTS = MAX_KNOTS_DEF;
  localparam int CHANNELS = CHANNELS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int NUM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic op;
    logic [CHAN_W-1:0] chan;
    logic [KIDX_W-1:0] kidx;
    logic [LEVEL_W-1:0] lin;
    logic [LEVEL_W-1:0] lout;
    logic [LEVEL_W-1:0] pix;
  } tone_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [CHAN_W-1:0] chan;
  } tone_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic op = OP_LOAD;
  logic [CHAN_W-1:0] channel = '0;
  logic [KIDX_W-1:0] knot_index = '0;
  logic [LEVEL_W-1:0] knot_level_in = '0;
  logic [LEVEL_W-1:0] knot_level_out = '0;
  logic [LEVEL_W-1:0] pixel = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [LEVEL_W-1:0] mapped;
  logic [CHAN_W-1:0] out_channel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Stimulus side
  tone_item_t pending_items[$];
  bit knot_loaded [CHANNELS][MAX_KNOTS];
  logic [LEVEL_W-1:0] loaded_level [CHANNELS][MAX_KNOTS];
  logic [CFG_W-1:0] planned_count [CHANNELS];
  int useful_items = 0;
  logic steady = 1'b0;

  // Predictor state
  logic [LEVEL_W-1:0] curve_in [CHANNELS*MAX_KNOTS];
  logic [LEVEL_W-1:0] curve_out [CHANNELS*MAX_KNOTS];
  logic [CFG_W-1:0] knot_count [CHANNELS];
  tone_result_t expected_results[$];

  int err_count = 0;
  int cycle_count = 0;

  piecewise_linear_tone_curve #(
    .MAX_KNOTS(MAX_KNOTS),
    .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .op(op),
    .channel(channel),
    .knot_index(knot_index),
    .knot_level_in(knot_level_in),
    .knot_level_out(knot_level_out),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .mapped(mapped),
    .out_channel(out_channel),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp a knot count register to the usable range
  function automatic int knots_used(input logic [CFG_W-1:0] raw);
    int n;
    n = raw;
    if (n < MIN_KNOTS) n = MIN_KNOTS;
    if (n > MAX_KNOTS) n = MAX_KNOTS;
    return n;
  endfunction

  // Expected curve output for one pixel on one channel
  function automatic logic [LEVEL_W-1:0] tone_map(input int ch, input logic [LEVEL_W-1:0] v);
    int base, n, j, x0, x1, y0, y1, dx, t, q;
    base = ch * MAX_KNOTS;
    n = knots_used(knot_count[ch]);
    j = 0;
    while (j < n && curve_in[base+j] < v) j++;
    if (j >= n) return curve_out[base+n-1];
    x1 = curve_in[base+j];
    y1 = curve_out[base+j];
    if (x1 == v || j == 0) return y1;
    x0 = curve_in[base+j-1];
    y0 = curve_out[base+j-1];
    dx = x1 - x0;
    t = v - x0;
    q = (y0 * (dx - t) + y1 * t) / dx;
    if (q > 255) q = 255;
    return q[LEVEL_W-1:0];
  endfunction

  task automatic add_item(input logic o, input int ch, input int ki, input int li,
                          input int lo, input int px);
    tone_item_t it;
    it.op = o;
    it.chan = ch[CHAN_W-1:0];
    it.kidx = ki[KIDX_W-1:0];
    it.lin = li[LEVEL_W-1:0];
    it.lout = lo[LEVEL_W-1:0];
    it.pix = px[LEVEL_W-1:0];
    pending_items.push_back(it);
    if (it.chan < CHANNELS) begin
      useful_items++;
      if (o == OP_LOAD) begin
        knot_loaded[it.chan][it.kidx] = 1'b1;
        loaded_level[it.chan][it.kidx] = it.lin;
      end
    end
  endtask

  task automatic add_load(input int ch, input int ki, input int li, input int lo);
    add_item(OP_LOAD, ch, ki, li, lo, $urandom_range(255));
  endtask

  task automatic add_map(input int ch, input int px);
    add_item(OP_MAP, ch, $urandom_range(15), $urandom_range(255), $urandom_range(255), px);
  endtask

  // Load knots 0..n-1 of one channel, ascending unless scrambled
  task automatic load_curve(input int ch, input int n, input bit scrambled);
    int lv [MAX_KNOTS];
    int i, j, key;
    for (i = 0; i < n; i++) lv[i] = $urandom_range(255);
    if (!scrambled) begin
      for (i = 1; i < n; i++) begin
        key = lv[i];
        j = i;
        while (j > 0 && lv[j-1] > key) begin
          lv[j] = lv[j-1];
          j--;
        end
        lv[j] = key;
      end
      if ($urandom_range(3) == 0) begin
        lv[0] = 0;
        lv[n-1] = 255;
      end
    end
    for (i = 0; i < n; i++) add_load(ch, i, lv[i], $urandom_range(255));
  endtask

  // Pick a pixel, often on or next to a loaded knot level
  function automatic int pick_pixel(input int ch);
    int k;
    if ($urandom_range(9) < 4) begin
      k = $urandom_range(knots_used(planned_count[ch]) - 1);
      return (loaded_level[ch][k] + $urandom_range(2) + 255) % 256;
    end
    return $urandom_range(255);
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < NUM_CFG) planned_count[idx] = data;
  endtask

  // Wait until every item is taken and every result is back, then let the block drain
  task automatic settle();
    do @(posedge clk);
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // Item driver: hold each transaction until accepted, idle at random
  always @(posedge clk) begin
    tone_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
        nxt = pending_items.pop_front();
        item_valid <= 1'b1;
        op <= nxt.op;
        channel <= nxt.chan;
        knot_index <= nxt.kidx;
        knot_level_in <= nxt.lin;
        knot_level_out <= nxt.lout;
        pixel <= nxt.pix;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: check results, then advance the predictor on accepted transactions
  always @(posedge clk) begin
    tone_result_t want;
    int addr;
    if (rst) begin
      result_ready <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) knot_count[c] = CFG_W'(MIN_KNOTS);
    end else begin
      result_ready <= steady || ($urandom_range(99) >= 16);
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: mapped=%0d out_channel=%0d",
                                 mapped, out_channel));
        end else begin
          want = expected_results.pop_front();
          if (mapped !== want.level || out_channel !== want.chan)
            note_failure($sformatf("mismatch: mapped exp %0d got %0d, out_channel exp %0d got %0d",
                                   want.level, mapped, want.chan, out_channel));
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_CFG) knot_count[cfg_index] = cfg_data;
      if (item_valid && item_ready && channel < CHANNELS) begin
        if (op == OP_LOAD) begin
          addr = channel * MAX_KNOTS + knot_index;
          curve_in[addr] = knot_level_in;
          curve_out[addr] = knot_level_out;
        end else begin
          want.level = tone_map(channel, pixel);
          want.chan = channel;
          expected_results.push_back(want);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int c0, c1, c2, target, r, ch, n;
    for (int c = 0; c < CHANNELS; c++) planned_count[c] = CFG_W'(MIN_KNOTS);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Two-knot curves under the reset counts: identity, falling, inner span
    add_load(0, 0, 0, 0);
    add_load(0, 1, 255, 255);
    add_load(1, 0, 64, 255);
    add_load(1, 1, 192, 0);
    add_load(2, 0, 10, 200);
    add_load(2, 1, 250, 30);
    add_map(0, 0);
    add_map(0, 255);
    add_map(0, 127);
    // Below first knot, exact hit, between, last knot, above last
    add_map(1, 0);
    add_map(1, 64);
    add_map(1, 100);
    add_map(1, 192);
    add_map(1, 255);
    add_map(2, 9);
    add_map(2, 11);
    add_map(2, 249);
    add_map(2, 250);
    add_map(2, 251);
    // Nonexistent channel: load is dropped, map yields nothing
    add_item(OP_LOAD, 3, 15, 255, 255, 255);
    add_item(OP_MAP, 3, 0, 0, 0, 255);
    // Top knot index outside the active count
    add_load(0, 15, 255, 0);
    add_map(0, 200);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      steady <= (phase == 4);
      case (phase)
        0: begin
          c0 = 0; c1 = 1; c2 = 31;
        end
        1: begin
          c0 = 16; c1 = 2; c2 = 17;
        end
        2: begin
          c0 = 3; c1 = 16; c2 = 5;
        end
        default: begin
          c0 = $urandom_range(31); c1 = $urandom_range(31); c2 = $urandom_range(31);
        end
      endcase
      write_register(REG_KNOTS_CH0, CFG_W'(c0));
      write_register(REG_KNOTS_CH1, CFG_W'(c1));
      write_register(REG_KNOTS_CH2, CFG_W'(c2));
      write_register(REG_SPARE, CFG_W'($urandom_range(31)));

      // Make sure every knot in use is loaded before any map reads it
      for (int c = 0; c < CHANNELS; c++) begin
        n = knots_used(planned_count[c]);
        r = 0;
        for (int k = 0; k < n; k++) if (!knot_loaded[c][k]) r = 1;
        if (r != 0 || $urandom_range(2) == 0)
          load_curve(c, $urandom_range(n, MAX_KNOTS), $urandom_range(3) == 0);
      end

      target = useful_items + ITEMS_PER_PHASE;
      while (useful_items < target) begin
        r = $urandom_range(99);
        ch = $urandom_range(CHANNELS - 1);
        if (r < 8) begin
          add_item(1'($urandom_range(1)), 3, $urandom_range(15), $urandom_range(255),
                   $urandom_range(255), $urandom_range(255));
        end else if (r < 16) begin
          load_curve(ch, knots_used(planned_count[ch]), $urandom_range(3) == 0);
        end else if (r < 26) begin
          add_load(ch, $urandom_range(15), $urandom_range(255), $urandom_range(255));
        end else begin
          add_map(ch, pick_pixel(ch));
        end
      end
    end

    settle();
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
